[src/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared sizes, operation codes and the queue entry type for the page map
// translation block.
// ----------------------------------------------------------------------------
package pmt_pkg;

  // geometry of the flash and of the logical space
  localparam int PAGES_PER_BLOCK = 32;
  localparam int PHYS_BLOCKS     = 16;
  localparam int LOGICAL_PAGES   = 256;
  localparam int TOTAL_PAGES     = PAGES_PER_BLOCK * PHYS_BLOCKS;

  // field widths
  localparam int LBA_W   = 8;
  localparam int BLOCK_W = 4;
  localparam int PAGE_W  = 5;
  localparam int TOTAL_W = 10;
  localparam int MAP_AW  = $clog2(LOGICAL_PAGES);
  localparam int LOC_W   = BLOCK_W + PAGE_W;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // request command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // classified operation carried to the back end
  typedef enum logic [2:0] {
    OP_READ  = 3'b001,
    OP_WRITE = 3'b010,
    OP_FULL  = 3'b100
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [MAP_AW-1:0]   idx;
    logic [BLOCK_W-1:0]  blk;
    logic [PAGE_W-1:0]   pg;
    logic [TOTAL_W-1:0]  total;
  } entry_t;

endpackage

[src/pmt_front.sv]
// ----------------------------------------------------------------------------
// pmt_front
// Accepts requests, classifies them and runs the sequential page allocator
// and the write counter. Each request leaves as one queue entry.
// ----------------------------------------------------------------------------
module pmt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [pmt_pkg::LBA_W-1:0]     lba,
  input  logic                          q_full,
  output logic                          push,
  output pmt_pkg::entry_t               push_entry
);
  import pmt_pkg::*;

  logic [BLOCK_W-1:0] alloc_block;
  logic [PAGE_W-1:0]  alloc_page;
  logic               store_full;
  logic [TOTAL_W-1:0] write_total;

  logic is_write;
  logic do_alloc;
  logic page_last;
  logic block_last;

  // handshake
  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // classification
  assign is_write   = (cmd == CMD_WRITE);
  assign do_alloc   = push && is_write && !store_full;
  assign page_last  = (alloc_page == PAGE_W'(PAGES_PER_BLOCK - 1));
  assign block_last = (alloc_block == BLOCK_W'(PHYS_BLOCKS - 1));

  // queue entry, count already reflects this request
  always_comb begin
    if (!is_write) begin
      push_entry.op = OP_READ;
    end else if (store_full) begin
      push_entry.op = OP_FULL;
    end else begin
      push_entry.op = OP_WRITE;
    end
    push_entry.idx   = lba[MAP_AW-1:0];
    push_entry.blk   = alloc_block;
    push_entry.pg    = alloc_page;
    push_entry.total = (is_write && !store_full) ? write_total + TOTAL_W'(1) : write_total;
  end

  // allocator walks pages, then blocks, and stops when all are used
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_block <= '0;
      alloc_page  <= '0;
      store_full  <= 1'b0;
      write_total <= '0;
    end else if (do_alloc) begin
      write_total <= write_total + TOTAL_W'(1);
      if (page_last) begin
        alloc_page <= '0;
        if (block_last) begin
          store_full <= 1'b1;
        end else begin
          alloc_block <= alloc_block + BLOCK_W'(1);
        end
      end else begin
        alloc_page <= alloc_page + PAGE_W'(1);
      end
    end
  end

endmodule

[src/pmt_queue.sv]
// ----------------------------------------------------------------------------
// pmt_queue
// Short first-in first-out queue of classified requests between the front
// and the back end.
// ----------------------------------------------------------------------------
module pmt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pmt_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output pmt_pkg::entry_t  pop_entry,
  output logic             not_empty
);
  import pmt_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

[src/pmt_back.sv]
// ----------------------------------------------------------------------------
// pmt_back
// Carries out queued requests against the logical-to-physical map and
// holds the response register.
// ----------------------------------------------------------------------------
module pmt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          not_empty,
  input  pmt_pkg::entry_t               pop_entry,
  output logic                          pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          mapped,
  output logic [pmt_pkg::BLOCK_W-1:0]   phys_block,
  output logic [pmt_pkg::PAGE_W-1:0]    phys_page,
  output logic                          full_error,
  output logic [pmt_pkg::TOTAL_W-1:0]   pages_written
);
  import pmt_pkg::*;

  typedef enum logic [2:0] {
    ST_FETCH = 3'b001,
    ST_LOOK  = 3'b010,
    ST_SEND  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [LOC_W-1:0]         map_mem [LOGICAL_PAGES];
  logic [LOGICAL_PAGES-1:0] valid_bits;
  logic [LOC_W-1:0]         rd_data;
  logic                     rd_valid;
  logic [TOTAL_W-1:0]       pend_total;
  logic                     map_wr;

  assign pop       = (state == ST_FETCH) && not_empty;
  assign map_wr    = pop && (pop_entry.op == OP_WRITE);
  assign rsp_valid = (state == ST_SEND);

  // map storage, registered read
  always_ff @(posedge clk) begin
    if (map_wr) begin
      map_mem[pop_entry.idx] <= {pop_entry.blk, pop_entry.pg};
    end
    rd_data <= map_mem[pop_entry.idx];
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (map_wr) begin
        valid_bits[pop_entry.idx] <= 1'b1;
      end
      rd_valid <= valid_bits[pop_entry.idx];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_FETCH: begin
        if (pop) begin
          state_next = (pop_entry.op == OP_READ) ? ST_LOOK : ST_SEND;
        end
      end
      ST_LOOK: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!rsp_stall) begin
          state_next = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (pop) begin
      pend_total <= pop_entry.total;
      case (pop_entry.op)
        OP_WRITE: begin
          mapped        <= 1'b1;
          phys_block    <= pop_entry.blk;
          phys_page     <= pop_entry.pg;
          full_error    <= 1'b0;
          pages_written <= pop_entry.total;
        end
        OP_FULL: begin
          mapped        <= 1'b0;
          phys_block    <= '0;
          phys_page     <= '0;
          full_error    <= 1'b1;
          pages_written <= pop_entry.total;
        end
        default: begin
        end
      endcase
    end else if (state == ST_LOOK) begin
      mapped        <= rd_valid;
      phys_block    <= rd_valid ? rd_data[LOC_W-1:PAGE_W] : '0;
      phys_page     <= rd_valid ? rd_data[PAGE_W-1:0] : '0;
      full_error    <= 1'b0;
      pages_written <= pend_total;
    end
  end

endmodule

[src/page_map_translation.sv]
// Response: a write or full request is answered once the back end pops it
// from the queue; a read first passes a look-up state for the registered map read.
// Sequencing: the back-end sequencer takes one request at a time (fetch, then
// look-up for reads, then send until not stalled); a 4-entry queue lets requests arrive meanwhile.
// Reset: synchronous; clears the allocator, the write count, the queue and
// all map valid bits at once, so the block takes requests right after reset.
// ----------------------------------------------------------------------------
// page_map_translation
// Page-level flash translation map: reads look up a logical page, writes
// take the next free physical page from a sequential allocator.
// ----------------------------------------------------------------------------
module page_map_translation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [pmt_pkg::LBA_W-1:0]     lba,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          mapped,
  output logic [pmt_pkg::BLOCK_W-1:0]   phys_block,
  output logic [pmt_pkg::PAGE_W-1:0]    phys_page,
  output logic                          full_error,
  output logic [pmt_pkg::TOTAL_W-1:0]   pages_written
);
  import pmt_pkg::*;

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_not_empty;
  entry_t push_entry;
  entry_t pop_entry;

  // request classification and allocation
  pmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .lba        (lba),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  pmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  // map access and response
  pmt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (q_not_empty),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .mapped        (mapped),
    .phys_block    (phys_block),
    .phys_page     (phys_page),
    .full_error    (full_error),
    .pages_written (pages_written)
  );

endmodule

[src/pmt_checker.sv]
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks on the responses of the page map translation block.
// ----------------------------------------------------------------------------
module pmt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic                          mapped,
  input  logic [pmt_pkg::BLOCK_W-1:0]   phys_block,
  input  logic [pmt_pkg::PAGE_W-1:0]    phys_page,
  input  logic                          full_error,
  input  logic [pmt_pkg::TOTAL_W-1:0]   pages_written
);
  import pmt_pkg::*;

  // a stalled response stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // a failed write never carries a location
  a_full_unmapped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && full_error |-> !mapped)
    else $error("full response marked mapped");

  // full is only reported once every physical page is used
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && full_error |-> pages_written == TOTAL_W'(TOTAL_PAGES))
    else $error("full reported before all pages written");

  // a valid location implies at least one write so far
  a_mapped_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && mapped |-> pages_written != '0)
    else $error("mapped response with no writes");

  // unmapped responses return a zero location
  a_zero_loc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !mapped |-> phys_block == '0 && phys_page == '0)
    else $error("unmapped response with nonzero location");

endmodule

bind page_map_translation pmt_checker u_pmt_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .mapped        (mapped),
  .phys_block    (phys_block),
  .phys_page     (phys_page),
  .full_error    (full_error),
  .pages_written (pages_written)
);
